// File: rtl/mar_pkg.sv
// ----------------------------------------------------------------------------
// mar_pkg
// Shared widths, command and status types for the moving average ring.
// ----------------------------------------------------------------------------
package mar_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_BITS    = 7;
    localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
    localparam int CNT_BITS    = SLOT_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
    localparam int DIV_STEPS   = SUM_BITS;
    localparam int STEP_BITS   = $clog2(DIV_STEPS);
    localparam int OUT_BITS    = SAMPLE_BITS + CNT_BITS;
    localparam int OUT_BYTES   = (OUT_BITS + 7) / 8;
    localparam int OUT_PAD     = OUT_BYTES * 8 - OUT_BITS;

    typedef struct packed {
        logic cfg_write;
        logic clear;
        logic push;
        logic sum;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last_step;
        logic out_free;
    } status_t;

endpackage

// File: rtl/mar_ctrl.sv
// ----------------------------------------------------------------------------
// mar_ctrl
// Sequencer: accepts words and config writes, steps sum, divide and output.
// ----------------------------------------------------------------------------
module mar_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             func,
    output logic             s_tready,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  mar_pkg::status_t status,
    output mar_pkg::cmd_t    cmd
);
    import mar_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                end
                else if (s_tvalid)
                begin
                    if (func)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && cfg_valid))
        else $error("word accepted together with config write");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.last_step) |=> state_reg == ST_DONE)
        else $error("divide end not followed by output stage");

endmodule

// File: rtl/mar_dp.sv
// ----------------------------------------------------------------------------
// mar_dp
// Datapath: ring store, running sum, held count, serial divider, output word.
// ----------------------------------------------------------------------------
module mar_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mar_pkg::cmd_t                       cmd,
    output mar_pkg::status_t                    status,
    input  logic [mar_pkg::WIN_BITS-1:0]        cfg_data,
    input  logic signed [mar_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic signed [mar_pkg::SAMPLE_BITS-1:0] average,
    output logic [mar_pkg::CNT_BITS-1:0]        samples_held
);
    import mar_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

    logic [WIN_BITS-1:0]    win_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [CNT_BITS-1:0]    held_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] rd_reg;
    logic [SUM_BITS-1:0]    quo_reg;
    logic [CNT_BITS-1:0]    rem_reg;
    logic [CNT_BITS-1:0]    div_reg;
    logic                   neg_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   valid_reg;

    logic [CNT_BITS-1:0]    eff_win;
    logic                   warm;
    logic [SAMPLE_BITS-1:0] old_val;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SUM_BITS-1:0]    mag;
    logic [CNT_BITS-1:0]    slot_inc;
    logic [SLOT_BITS-1:0]   slot_next;
    logic [CNT_BITS-1:0]    held_next;
    logic [CNT_BITS:0]      trial;
    logic [CNT_BITS:0]      diff;
    logic [SAMPLE_BITS-1:0] quo_low;

    always_comb
    begin
        if (win_reg == '0)
        begin
            eff_win = CNT_BITS'(1);
        end
        else if (int'(win_reg) > MAX_WINDOW)
        begin
            eff_win = CNT_BITS'(MAX_WINDOW);
        end
        else
        begin
            eff_win = CNT_BITS'(win_reg);
        end
    end

    assign warm     = held_reg < eff_win;
    assign old_val  = warm ? '0 : rd_reg;
    assign sum_next = sum_reg
                    + {{(SUM_BITS-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg}
                    - {{(SUM_BITS-SAMPLE_BITS){old_val[SAMPLE_BITS-1]}}, old_val};
    assign mag       = sum_next[SUM_BITS-1] ? (~sum_next + SUM_BITS'(1)) : sum_next;
    assign slot_inc  = {1'b0, slot_reg} + CNT_BITS'(1);
    assign slot_next = (slot_inc >= eff_win) ? '0 : slot_inc[SLOT_BITS-1:0];
    assign held_next = warm ? (held_reg + CNT_BITS'(1)) : held_reg;

    assign trial   = {rem_reg, quo_reg[SUM_BITS-1]};
    assign diff    = trial - {1'b0, div_reg};
    assign quo_low = quo_reg[SAMPLE_BITS-1:0];

    assign status.last_step = step_reg == STEP_BITS'(DIV_STEPS - 1);
    assign status.out_free  = !valid_reg || m_tready;

    assign m_tvalid     = valid_reg;
    assign average      = avg_reg;
    assign samples_held = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            rd_reg <= mem[slot_reg];
        end
        if (cmd.sum)
        begin
            mem[slot_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WIN_BITS'(64);
            slot_reg <= '0;
            held_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.cfg_write)
        begin
            win_reg  <= cfg_data;
            slot_reg <= '0;
            held_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            slot_reg <= '0;
            held_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.sum)
        begin
            slot_reg <= slot_next;
            held_reg <= held_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            sample_reg <= sample;
        end
        if (cmd.clear)
        begin
            quo_reg <= '0;
            neg_reg <= 1'b0;
        end
        else if (cmd.sum)
        begin
            quo_reg  <= mag;
            rem_reg  <= '0;
            div_reg  <= held_next;
            neg_reg  <= sum_next[SUM_BITS-1];
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!diff[CNT_BITS])
            begin
                rem_reg <= diff[CNT_BITS-1:0];
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CNT_BITS-1:0];
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
            end
            step_reg <= step_reg + STEP_BITS'(1);
        end
        if (cmd.load_out)
        begin
            avg_reg <= neg_reg ? (~quo_low + SAMPLE_BITS'(1)) : quo_low;
            cnt_reg <= held_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= eff_win)
        else $error("held count above window");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_BITS'(slot_reg) < eff_win)
        else $error("write slot outside window");

    a_warm_slot: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> CNT_BITS'(slot_reg) == held_reg)
        else $error("write slot and held count out of step during warm-up");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |-> !cmd.load_out)
        else $error("output word overwritten while stalled");

endmodule

// File: rtl/moving_average_ring.sv
// ----------------------------------------------------------------------------
// moving_average_ring
// Moving average over a configurable window held in a ring store.
//
//  channel  direction  handshake               payload
//  s_*      in         s_tvalid / s_tready     tuser: func; tdata: sample
//  m_*      out        m_tvalid / m_tready     tdata: average, samples_held
//  cfg_*    in         cfg_valid / cfg_ready   cfg_data: window_len
//
// A push word is read from the store on the accept edge, then takes one sum
// update and the one-bit-per-cycle restoring divider before the output load.
// A clear word goes from accept straight to the output load.
// The next word is accepted at the earliest the cycle after the output load, so
// a new word is taken only when the last is through; a stalled output word holds
// the next result in the sequencer's last stage with s_tready low.
// Reset is asynchronous; the store needs no clearing pass, the held count
// masks entries not yet written.
// ----------------------------------------------------------------------------
module moving_average_ring
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mar_pkg::SAMPLE_BITS-1:0]      s_tdata,  // [15:0] sample
    input  logic                                 s_tuser,  // [0] func
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mar_pkg::OUT_BYTES*8-1:0]      m_tdata,  // [15:0] average, [22:16] samples_held
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mar_pkg::WIN_BITS-1:0]         cfg_data
);
    import mar_pkg::*;

    cmd_t                   cmd;
    status_t                status;
    logic [SAMPLE_BITS-1:0] average;
    logic [CNT_BITS-1:0]    samples_held;

    mar_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .func      (s_tuser),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mar_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_data     (cfg_data),
        .sample       (s_tdata),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .average      (average),
        .samples_held (samples_held)
    );

    assign m_tdata = {{OUT_PAD{1'b0}}, samples_held, average};

endmodule

// File: bench/tb_moving_average_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_ring
// Self-checking bench for the moving average ring. A short table of words and
// window writes covers sample extremes, clear, warm-up, truncation toward zero
// and out-of-range window lengths. Random phases follow, most with a new window
// length. Output words are checked against typed table values or an in-bench
// filter copy, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_moving_average_ring;

    import mar_pkg::*;

    typedef enum logic {OP_PUSH = 1'b0, OP_CLEAR = 1'b1} op_t;
    typedef enum logic {ROW_WORD = 1'b0, ROW_WINDOW = 1'b1} row_kind_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]           held;
        logic signed [SAMPLE_BITS-1:0] average;
    } avg_result_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [WIN_BITS-1:0]     window;
        op_t                     op;
        logic [SAMPLE_BITS-1:0]  sample;
        logic                    typed;
        logic [SAMPLE_BITS-1:0]  average;
        logic [CNT_BITS-1:0]     held;
    } step_row_t;

    localparam int N_ROWS    = 28;
    localparam int LONG_HOLD = 300;

    localparam step_row_t DIRECTED [N_ROWS] = '{
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h7FFF, 1'b1, 16'h7FFF, 7'd1},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h8000, 1'b1, 16'h0000, 7'd2},
        '{ROW_WORD,   7'd0,   OP_CLEAR, 16'h5A5A, 1'b1, 16'h0000, 7'd0},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h8000, 1'b1, 16'h8000, 7'd1},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h8000, 1'b1, 16'h8000, 7'd2},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h0001, 1'b0, 16'h0000, 7'd0},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h7FFF, 1'b0, 16'h0000, 7'd0},
        '{ROW_WINDOW, 7'd0,   OP_PUSH,  16'h0000, 1'b0, 16'h0000, 7'd0},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h3039, 1'b1, 16'h3039, 7'd1},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'hFFF9, 1'b1, 16'hFFF9, 7'd1},
        '{ROW_WORD,   7'd0,   OP_CLEAR, 16'hFFFF, 1'b1, 16'h0000, 7'd0},
        '{ROW_WINDOW, 7'd2,   OP_PUSH,  16'h0000, 1'b0, 16'h0000, 7'd0},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h0064, 1'b1, 16'h0064, 7'd1},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h00C9, 1'b1, 16'h0096, 7'd2},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'hFED3, 1'b1, 16'hFFCE, 7'd2},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'hFFFD, 1'b0, 16'h0000, 7'd0},
        '{ROW_WINDOW, 7'd127, OP_PUSH,  16'h0000, 1'b0, 16'h0000, 7'd0},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h7FFF, 1'b1, 16'h7FFF, 7'd1},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'hFFFF, 1'b1, 16'h3FFF, 7'd2},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h5555, 1'b0, 16'h0000, 7'd0},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'hAAAA, 1'b0, 16'h0000, 7'd0},
        '{ROW_WINDOW, 7'd64,  OP_PUSH,  16'h0000, 1'b0, 16'h0000, 7'd0},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'hFFFF, 1'b1, 16'hFFFF, 7'd1},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h0002, 1'b1, 16'h0000, 7'd2},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'hFFFC, 1'b1, 16'hFFFF, 7'd3},
        '{ROW_WORD,   7'd0,   OP_CLEAR, 16'h1234, 1'b1, 16'h0000, 7'd0},
        '{ROW_WINDOW, 7'd1,   OP_PUSH,  16'h0000, 1'b0, 16'h0000, 7'd0},
        '{ROW_WORD,   7'd0,   OP_PUSH,  16'h0005, 1'b1, 16'h0005, 7'd1}
    };

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [SAMPLE_BITS-1:0]     s_tdata   = '0;   // [15:0] sample
    logic                       s_tuser   = 1'b0; // [0] func
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [OUT_BYTES*8-1:0]     m_tdata;          // [15:0] average, [22:16] samples_held
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [WIN_BITS-1:0]        cfg_data  = '0;

    logic                       steady    = 1'b0;
    logic                       long_hold = 1'b0;
    int unsigned                mismatches = 0;
    avg_result_t                expected_avgs [$];

    logic signed [SAMPLE_BITS-1:0] ring_copy [MAX_WINDOW];
    int unsigned                   ring_slot;
    int unsigned                   ring_held;
    longint                        ring_total;
    logic [WIN_BITS-1:0]           window_reg;

    moving_average_ring i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned effective_window(logic [WIN_BITS-1:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WINDOW)
            return MAX_WINDOW;
        return w;
    endfunction

    function automatic void clear_ring();
        foreach (ring_copy[i])
            ring_copy[i] = '0;
        ring_slot  = 0;
        ring_held  = 0;
        ring_total = 0;
    endfunction

    function automatic avg_result_t advance_filter(op_t op, logic signed [SAMPLE_BITS-1:0] sample);
        int unsigned w;
        avg_result_t r;
        longint      q;
        w = effective_window(window_reg);
        r = '0;
        if (op == OP_CLEAR)
        begin
            clear_ring();
        end
        else
        begin
            if (ring_slot >= w)
                ring_slot = 0;
            ring_total += longint'(sample) - longint'(ring_copy[ring_slot]);
            ring_copy[ring_slot] = sample;
            ring_slot++;
            if (ring_slot >= w)
                ring_slot = 0;
            if (ring_held < w)
                ring_held++;
            q = ring_total / longint'(ring_held);
            r.average = q[SAMPLE_BITS-1:0];
        end
        r.held = ring_held[CNT_BITS-1:0];
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic note_mismatch(string field, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    task automatic send_word(op_t op, logic [SAMPLE_BITS-1:0] sample, logic typed,
                             avg_result_t typed_result);
        int unsigned gap;
        avg_result_t predicted;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= sample;
        do @(negedge clk); while (s_tready !== 1'b1);
        @(posedge clk);
        predicted = advance_filter(op, sample);
        expected_avgs.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_avgs.size() != 0);
    endtask

    task automatic write_window(logic [WIN_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge clk); while (cfg_ready !== 1'b1);
        @(posedge clk);
        cfg_valid  <= 1'b0;
        window_reg  = value;
        clear_ring();
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned words;
        int unsigned n;
        int unsigned random_words;
        logic [WIN_BITS-1:0] w;
        op_t op;
        window_reg = 7'd64;
        clear_ring();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_WINDOW)
            begin
                wait_idle();
                write_window(DIRECTED[i].window);
            end
            else
            begin
                send_word(DIRECTED[i].op, DIRECTED[i].sample, DIRECTED[i].typed,
                          avg_result_t'{DIRECTED[i].held, DIRECTED[i].average});
            end
        end

        random_words = 0;
        phase        = 0;
        while (random_words < 900)
        begin
            wait_idle();
            case (phase)
                0:       w = 7'd0;
                1:       w = 7'd1;
                2:       w = 7'd64;
                3:       w = 7'd127;
                4:       w = 7'd65;
                default:
                begin
                    if ($urandom_range(0, 9) < 6)
                        w = WIN_BITS'($urandom_range(2, 8));
                    else if ($urandom_range(0, 3) == 0)
                        w = 7'd64;
                    else
                        w = WIN_BITS'($urandom_range(0, 127));
                end
            endcase
            // keep the old window and filter state now and then
            if (phase < 5 || $urandom_range(0, 4) != 0)
                write_window(w);
            steady = (phase % 4 == 3);
            words  = 3 * effective_window(window_reg) + $urandom_range(1, 12);
            if (words > 140)
                words = 140;
            if (words > 900 - random_words)
                words = 900 - random_words;
            for (n = 0; n < words; n++)
            begin
                if (phase == 2 && n == 10)
                    long_hold = 1'b1;
                if (phase == 6 && n == words / 2)
                    wait_idle();
                op = ($urandom_range(0, (phase % 5 == 2) ? 3 : 24) == 0) ? OP_CLEAR : OP_PUSH;
                send_word(op, pick_sample(), 1'b0, '0);
                random_words++;
            end
            phase++;
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb_moving_average_ring passed");
        else
            $display("tb_moving_average_ring failed");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned hold;
        avg_result_t got;
        avg_result_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = draw_gap();
            if (long_hold)
            begin
                hold      = LONG_HOLD;
                long_hold = 1'b0;
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (m_tvalid !== 1'b1);
            got.average = m_tdata[SAMPLE_BITS-1:0];
            got.held    = m_tdata[SAMPLE_BITS +: CNT_BITS];
            if (expected_avgs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: average %0d, samples_held %0d",
                             got.average, got.held);
            end
            else
            begin
                want = expected_avgs.pop_front();
                if (got.average !== want.average)
                    note_mismatch("average", want.average, got.average);
                if (got.held !== want.held)
                    note_mismatch("samples_held", want.held, got.held);
            end
            @(posedge clk);
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb_moving_average_ring failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mar_pkg.sv
rtl/mar_ctrl.sv
rtl/mar_dp.sv
rtl/moving_average_ring.sv
bench/tb_moving_average_ring.sv
